@@ rtl/ogpt_pkg.sv @@
`timescale 1ns / 1ps

package ogpt_pkg;

  // geometry of the two stores
  localparam int SHEET_DIM  = 64;
  localparam int PIECE_DIM  = 32;
  localparam int MARK_WIDTH = 16;

  localparam int SHEET_AW    = $clog2(SHEET_DIM);
  localparam int PIECE_AW    = $clog2(PIECE_DIM);
  localparam int SHEET_CELLS = SHEET_DIM * SHEET_DIM;
  localparam int PIECE_CELLS = PIECE_DIM * PIECE_DIM;
  localparam int SHEET_ADDR_W = 2 * SHEET_AW;
  localparam int PIECE_ADDR_W = 2 * PIECE_AW;

  // fixed field widths
  localparam int MODE_W = 2;
  localparam int POS_W  = 6;
  localparam int DIM_W  = 6;
  localparam int CFG_W  = 7;
  localparam int MARK_IN_W = 16;
  localparam int CFG_IDX_W = 1;

  // width for placement sums and clipped bounds
  localparam int SUM_W = CFG_W + 1;
  // width of a per-item row or column count
  localparam int CNT_W = PIECE_AW + 1;

  // item modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STAMP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_COLS = 1'b1;

  localparam logic [CFG_W-1:0] SHEET_DIM_RESET = CFG_W'(SHEET_DIM);

  // sheet memory port request
  typedef struct packed {
    logic                    we;
    logic [SHEET_ADDR_W-1:0] waddr;
    logic [MARK_WIDTH-1:0]   wdata;
    logic [SHEET_ADDR_W-1:0] raddr;
  } sheet_req_t;

  // piece bitmap port request
  typedef struct packed {
    logic                    we;
    logic [PIECE_ADDR_W-1:0] waddr;
    logic                    wdata;
    logic [PIECE_ADDR_W-1:0] raddr;
  } piece_req_t;

endpackage

@@ rtl/ogpt_sheet_mem.sv @@
`timescale 1ns / 1ps

module ogpt_sheet_mem import ogpt_pkg::*; (
  input  logic                  clk,
  input  sheet_req_t            req,
  output logic [MARK_WIDTH-1:0] rdata
);

  logic [MARK_WIDTH-1:0] mem [SHEET_CELLS];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ rtl/ogpt_piece_mem.sv @@
`timescale 1ns / 1ps

module ogpt_piece_mem import ogpt_pkg::*; (
  input  logic       clk,
  input  piece_req_t req,
  output logic       rdata
);

  logic mem [PIECE_CELLS];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ rtl/ogpt_ctrl.sv @@
`timescale 1ns / 1ps

module ogpt_ctrl import ogpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_W-1:0]     mode,
  input  logic [POS_W-1:0]      pos_row,
  input  logic [POS_W-1:0]      pos_col,
  input  logic                  piece_bit,
  input  logic [DIM_W-1:0]      piece_rows,
  input  logic [DIM_W-1:0]      piece_cols,
  input  logic [MARK_IN_W-1:0]  mark_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [MODE_W-1:0]     done_mode,
  output sheet_req_t            sheet_req,
  input  logic [MARK_WIDTH-1:0] sheet_rdata,
  output piece_req_t            piece_req,
  input  logic                  piece_rdata
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  localparam logic [SUM_W-1:0] SHEET_LIM = SUM_W'(SHEET_DIM);
  localparam logic [SUM_W-1:0] PIECE_LIM = SUM_W'(PIECE_DIM);
  localparam logic [SHEET_ADDR_W-1:0] CLR_LAST = SHEET_ADDR_W'(SHEET_CELLS - 1);

  state_t state, state_next;

  logic [CFG_W-1:0]        sheet_rows;
  logic [CFG_W-1:0]        sheet_cols;
  logic [SHEET_ADDR_W-1:0] clr_cnt;

  logic [MODE_W-1:0]       cur_mode;
  logic [POS_W-1:0]        prow;
  logic [POS_W-1:0]        pcol;
  logic [MARK_WIDTH-1:0]   mark;
  logic [CNT_W-1:0]        row_cnt;
  logic [CNT_W-1:0]        col_cnt;
  logic [PIECE_AW-1:0]     row_off;
  logic [PIECE_AW-1:0]     col_off;
  logic                    hit_acc;

  logic                    stg_vld;
  logic [SHEET_ADDR_W-1:0] stg_si;

  logic                    accept;
  logic                    walk_mode;
  logic [SUM_W-1:0]        rlim, clim, nr, nc, prow_e, pcol_e;
  logic [SUM_W-1:0]        rend_raw, cend_raw, rend, cend, rcnt, ccnt;
  logic                    load_in_range;
  logic                    col_last, row_last;
  logic [SUM_W-1:0]        cur_row, cur_col;
  logic [SHEET_ADDR_W-1:0] cur_si;
  logic                    slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign walk_mode = (mode == MODE_TEST) || (mode == MODE_STAMP);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_rows <= SHEET_DIM_RESET;
      sheet_cols <= SHEET_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHEET_ROWS: sheet_rows <= cfg_data;
        REG_SHEET_COLS: sheet_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // clipped walk extent of the incoming item
  always_comb begin
    rlim   = (SUM_W'(sheet_rows) > SHEET_LIM) ? SHEET_LIM : SUM_W'(sheet_rows);
    clim   = (SUM_W'(sheet_cols) > SHEET_LIM) ? SHEET_LIM : SUM_W'(sheet_cols);
    nr     = (SUM_W'(piece_rows) > PIECE_LIM) ? PIECE_LIM : SUM_W'(piece_rows);
    nc     = (SUM_W'(piece_cols) > PIECE_LIM) ? PIECE_LIM : SUM_W'(piece_cols);
    prow_e = SUM_W'(pos_row);
    pcol_e = SUM_W'(pos_col);
    rend_raw = prow_e + nr;
    cend_raw = pcol_e + nc;
    rend   = (rend_raw > rlim) ? rlim : rend_raw;
    cend   = (cend_raw > clim) ? clim : cend_raw;
    rcnt   = (rend > prow_e) ? (rend - prow_e) : '0;
    ccnt   = (cend > pcol_e) ? (cend - pcol_e) : '0;
  end

  assign load_in_range = (SUM_W'(pos_row) < PIECE_LIM) && (SUM_W'(pos_col) < PIECE_LIM);

  // current cell of the walk
  assign col_last = (CNT_W'(col_off) + CNT_W'(1)) == col_cnt;
  assign row_last = (CNT_W'(row_off) + CNT_W'(1)) == row_cnt;
  assign cur_row  = SUM_W'(prow) + SUM_W'(row_off);
  assign cur_col  = SUM_W'(pcol) + SUM_W'(col_off);
  assign cur_si   = {cur_row[SHEET_AW-1:0], cur_col[SHEET_AW-1:0]};

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (walk_mode && (rcnt != '0) && (ccnt != '0)) begin
            state_next = ST_WALK;
          end else if (mode != MODE_NONE) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_WALK:  if (col_last && row_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      stg_vld <= 1'b0;
    end else begin
      state   <= state_next;
      stg_vld <= (state == ST_WALK);
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SHEET_ADDR_W'(1);
      end
    end
  end

  // item registers and walk counters
  always_ff @(posedge clk) begin
    stg_si <= cur_si;
    if (accept) begin
      cur_mode <= mode;
      prow     <= pos_row;
      pcol     <= pos_col;
      mark     <= mark_value[MARK_WIDTH-1:0];
      row_cnt  <= CNT_W'(rcnt);
      col_cnt  <= CNT_W'(ccnt);
      row_off  <= '0;
      col_off  <= '0;
      hit_acc  <= 1'b0;
    end else begin
      if (state == ST_WALK) begin
        if (col_last) begin
          col_off <= '0;
          row_off <= row_off + PIECE_AW'(1);
        end else begin
          col_off <= col_off + PIECE_AW'(1);
        end
      end
      if (stg_vld && (cur_mode == MODE_TEST) && piece_rdata && (sheet_rdata != '0)) begin
        hit_acc <= 1'b1;
      end
    end
  end

  // memory requests
  always_comb begin
    sheet_req.raddr = cur_si;
    if (state == ST_CLEAR) begin
      sheet_req.we    = 1'b1;
      sheet_req.waddr = clr_cnt;
      sheet_req.wdata = '0;
    end else begin
      sheet_req.we    = stg_vld && (cur_mode == MODE_STAMP) && piece_rdata;
      sheet_req.waddr = stg_si;
      sheet_req.wdata = mark;
    end
    piece_req.we    = accept && (mode == MODE_LOAD) && load_in_range;
    piece_req.waddr = {pos_row[PIECE_AW-1:0], pos_col[PIECE_AW-1:0]};
    piece_req.wdata = piece_bit;
    piece_req.raddr = {row_off, col_off};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && slot_free) begin
      hit       <= hit_acc;
      done_mode <= cur_mode;
    end
  end

  // no item is taken while the sheet is being cleared
  assert property (@(posedge clk) disable iff (rst) (state == ST_CLEAR) |-> !in_ready)
    else $error("item accepted during sheet clear");

  // the sheet is written only by the clear pass or a stamp
  assert property (@(posedge clk) disable iff (rst)
    sheet_req.we |-> ((state == ST_CLEAR) || (cur_mode == MODE_STAMP)))
    else $error("sheet write outside clear or stamp");

  // walk offsets stay inside the clipped extent
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> ((CNT_W'(row_off) < row_cnt) && (CNT_W'(col_off) < col_cnt)))
    else $error("walk offset past clipped extent");

  // only a test may report an overlap
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (done_mode == MODE_TEST))
    else $error("hit reported for a non-test item");

  // a finished item waits while the result slot is full
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && out_valid && !out_ready) |=> (state == ST_DONE))
    else $error("result overwritten before it was taken");

endmodule

@@ rtl/occupancy_grid_place_and_test_unit.sv @@
`timescale 1ns / 1ps
// a load, or a test or stamp whose clipped extent is empty, goes from idle straight to
//   the done state; a test or stamp over R x C clipped piece cells walks them one per
//   cycle, then drains the last read before done; a none item gives no result; the
//   result is registered once the result slot is free, and only then is a new item taken
// reset: a clearing pass writes zero into all 4096 sheet cells, one per cycle, and no
//   item is accepted until it ends; the piece bitmap is not cleared

module occupancy_grid_place_and_test_unit import ogpt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    mode,
  input  logic [POS_W-1:0]     pos_row,
  input  logic [POS_W-1:0]     pos_col,
  input  logic                 piece_bit,
  input  logic [DIM_W-1:0]     piece_rows,
  input  logic [DIM_W-1:0]     piece_cols,
  input  logic [MARK_IN_W-1:0] mark_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [MODE_W-1:0]    done_mode
);

  sheet_req_t            sheet_req;
  piece_req_t            piece_req;
  logic [MARK_WIDTH-1:0] sheet_rdata;
  logic                  piece_rdata;

  // sequencer, configuration and result register
  ogpt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .pos_row     (pos_row),
    .pos_col     (pos_col),
    .piece_bit   (piece_bit),
    .piece_rows  (piece_rows),
    .piece_cols  (piece_cols),
    .mark_value  (mark_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .done_mode   (done_mode),
    .sheet_req   (sheet_req),
    .sheet_rdata (sheet_rdata),
    .piece_req   (piece_req),
    .piece_rdata (piece_rdata)
  );

  // sheet marker store
  ogpt_sheet_mem u_sheet (
    .clk   (clk),
    .req   (sheet_req),
    .rdata (sheet_rdata)
  );

  // piece bitmap store
  ogpt_piece_mem u_piece (
    .clk   (clk),
    .req   (piece_req),
    .rdata (piece_rdata)
  );

endmodule
